### src/pdms_pkg.sv
package pdms_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 16;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  unit_index;
        logic [23:0] mean_distance;
        logic [15:0] max_distance;
        logic [7:0]  double_midrank;
        logic [13:0] mean_rank_distance;
        logic        too_few;
        logic        final_res;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic clear_count;
        logic init_i;
        logic step_i;
        logic init_j;
        logic step_j;
        logic acc_rank;
        logic store_rank;
        logic acc_dist;
        logic start_div;
        logic emit;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic count_lt2;
        logic j_done;
        logic i_done;
        logic div_done;
    } t_status;

endpackage

### src/pdms_ctrl.sv
module pdms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pdms_pkg::t_in_item i_in,
    input  pdms_pkg::t_status i_status,
    output pdms_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RINIT = 4'd1;
    localparam logic [3:0] S_RSCAN = 4'd2;
    localparam logic [3:0] S_RWAIT = 4'd3;
    localparam logic [3:0] S_RNEXT = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DSCAN = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_in.last) begin
                        n_state = S_RINIT;
                    end
                end
            end
            S_RINIT: begin
                if (i_status.count_lt2) begin
                    o_cmd.emit_err    = 1'b1;
                    o_cmd.clear_count = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.init_i = 1'b1;
                    o_cmd.init_j = 1'b1;
                    n_state      = S_RSCAN;
                end
            end
            S_RSCAN: begin
                o_cmd.acc_rank = 1'b1;
                o_cmd.step_j   = 1'b1;
                if (i_status.j_done) begin
                    n_state = S_RWAIT;
                end
            end
            S_RWAIT: begin
                o_cmd.acc_rank = 1'b1;
                n_state        = S_RNEXT;
            end
            S_RNEXT: begin
                o_cmd.store_rank = 1'b1;
                o_cmd.init_j     = 1'b1;
                if (i_status.i_done) begin
                    o_cmd.init_i = 1'b1;
                    n_state      = S_DINIT;
                end else begin
                    o_cmd.step_i = 1'b1;
                    n_state      = S_RSCAN;
                end
            end
            S_DINIT: begin
                o_cmd.init_j = 1'b1;
                n_state      = S_DSCAN;
            end
            S_DSCAN: begin
                o_cmd.acc_dist = 1'b1;
                o_cmd.step_j   = 1'b1;
                if (i_status.j_done) begin
                    n_state = S_DWAIT;
                end
            end
            S_DWAIT: begin
                o_cmd.acc_dist  = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.div_done) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.init_j = 1'b1;
                    if (i_status.i_done) begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.step_i = 1'b1;
                        n_state      = S_DSCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_idle_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.emit) else $error("emit while idle");
    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_in.last) |=> (r_state == S_RINIT))
        else $error("last did not start run");
    a_div_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_EMIT)) else $error("div sequence");

endmodule

### src/pdms_div.sv
module pdms_div #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0] o_quo,
    output logic                o_done
);

    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic [DEN_BITS:0]   n_trial;

    assign n_trial = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_BITS);
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, r_den}) begin
                r_rem <= n_trial - {1'b0, r_den};
                r_q   <= {r_q[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_q   <= {r_q[NUM_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quo  = r_q;
    assign o_done = !r_busy && !i_go;

endmodule

### src/pdms_dp.sv
module pdms_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdms_pkg::t_in_item i_in,
    input  pdms_pkg::t_cmd     i_cmd,
    output pdms_pkg::t_status  o_status,
    output logic               o_valid,
    output pdms_pkg::t_out_item o_out
);

    localparam int MAX_SAMPLES = pdms_pkg::MAX_SAMPLES;
    localparam int SAMPLE_BITS = pdms_pkg::SAMPLE_BITS;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int RW = $clog2(2 * MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_BITS + AW + 8;
    localparam int RSW = RW + AW + 7;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [RW-1:0]                 r_rank [MAX_SAMPLES];

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i, r_j;
    logic          r_j_done;
    logic signed [SAMPLE_BITS-1:0] r_xi, r_xj;
    logic [RW-1:0] r_ri, r_rj;
    logic          r_pv, r_pself;
    logic [CW-1:0] r_less, r_eq;
    logic [SW-1:0]  r_sum;
    logic [RSW-1:0] r_rsum;
    logic [SAMPLE_BITS:0] r_mx;
    logic [RSW-1:0] r_rsum_q;
    logic           r_phase;
    logic           r_go2;
    logic [SW-1:0]  w_q1;
    logic [SW-1:0]  w_q2;
    logic           w_d1, w_d2;
    logic [SW-1:0]  w_num;
    logic [AW:0]    w_den;
    logic signed [SAMPLE_BITS:0] w_diff;
    logic [SAMPLE_BITS:0] w_ad;
    logic [RW-1:0]  w_rd;
    logic [CW-1:0]  w_last;

    assign w_last = r_count - 1'b1;
    assign w_den  = (AW+1)'(w_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CW'(MAX_SAMPLES)) begin
            r_mem[r_count[AW-1:0]] <= i_in.sample[SAMPLE_BITS-1:0];
        end
        r_xj <= r_mem[r_j];
        r_xi <= r_mem[r_i];
        r_rj <= r_rank[r_j];
        r_ri <= r_rank[r_i];
        if (i_cmd.store_rank) begin
            r_rank[r_i] <= RW'(2 * r_less + r_eq + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_count) begin
            r_count <= '0;
        end else if (i_cmd.load && r_count < CW'(MAX_SAMPLES)) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_i) r_i <= '0;
        else if (i_cmd.step_i) r_i <= r_i + 1'b1;
        if (i_cmd.init_j) r_j <= '0;
        else if (i_cmd.step_j && !r_j_done) r_j <= r_j + 1'b1;
        r_pv    <= i_cmd.step_j;
        r_pself <= (r_j == r_i);
    end

    assign r_j_done = ({1'b0, r_j} == (AW+1)'(w_last));

    assign w_diff = $signed({r_xi[SAMPLE_BITS-1], r_xi}) - $signed({r_xj[SAMPLE_BITS-1], r_xj});
    assign w_ad   = w_diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-w_diff) : w_diff;
    assign w_rd   = (r_ri >= r_rj) ? r_ri - r_rj : r_rj - r_ri;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_j) begin
            r_less <= '0;
            r_eq   <= '0;
            r_sum  <= '0;
            r_rsum <= '0;
            r_mx   <= '0;
        end else begin
            if (i_cmd.acc_rank && r_pv) begin
                if (r_xj < r_xi) r_less <= r_less + 1'b1;
                else if (r_xj == r_xi) r_eq <= r_eq + 1'b1;
            end
            if (i_cmd.acc_dist && r_pv && !r_pself) begin
                r_sum  <= r_sum + SW'(w_ad);
                r_rsum <= r_rsum + RSW'(w_rd);
                if (w_ad > r_mx) r_mx <= w_ad;
            end
        end
    end

    assign w_num = r_go2 ? SW'({r_rsum_q, 7'd0}) : {r_sum[SW-9:0], 8'd0};

    pdms_div #(.NUM_BITS(SW), .DEN_BITS(AW+1)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.start_div || r_go2),
        .i_num(w_num), .i_den(w_den), .o_quo(w_q1), .o_done(w_d1)
    );
    assign w_q2 = w_q1;
    assign w_d2 = w_d1;

    logic [SW-1:0] r_q1;
    logic          r_done2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_go2   <= 1'b0;
            r_done2 <= 1'b0;
        end else begin
            r_go2 <= 1'b0;
            if (i_cmd.start_div) begin
                r_phase    <= 1'b0;
                r_done2    <= 1'b0;
                r_rsum_q   <= r_rsum;
            end else if (!r_phase && w_d1 && !r_go2 && !r_done2) begin
                r_q1    <= w_q1;
                r_phase <= 1'b1;
                r_go2   <= 1'b1;
            end else if (r_phase && w_d2 && !r_go2 && !r_done2) begin
                r_done2 <= 1'b1;
            end
            if (i_cmd.emit) r_done2 <= 1'b0;
        end
    end

    always_comb begin
        o_status.count_lt2 = (r_count < CW'(2));
        o_status.j_done    = r_j_done;
        o_status.i_done    = ({1'b0, r_i} == (AW+1)'(w_last));
        o_status.div_done  = r_done2 && !i_cmd.start_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit || i_cmd.emit_err;
        end
        o_out <= '0;
        if (i_cmd.emit_err) begin
            o_out.too_few   <= 1'b1;
            o_out.final_res <= 1'b1;
        end else begin
            o_out.unit_index         <= 6'(r_i);
            o_out.mean_distance      <= r_q1[23:0];
            o_out.max_distance       <= r_mx[15:0];
            o_out.double_midrank     <= 8'(r_ri);
            o_out.mean_rank_distance <= w_q2[13:0];
            o_out.final_res          <= o_status.i_done;
        end
    end

    a_err_lt2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_err |-> o_status.count_lt2) else $error("bad error result");
    a_emit_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_done2) else $error("emit before divide");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES)) else $error("count overflow");

endmodule

### src/pairwise_distance_midrank_summary.sv
// Channel  | Direction | Handshake            | Payload
// input    | in        | start / busy         | i_in (sample, last)
// result   | out       | o_valid strobe       | o_out (seven result fields)
// One item loads per cycle while idle; an item with last starts the run.
// Ranking compares each sample with every sample, one pair at a time.
// Each result then needs a distance scan, then two serial divides (mean
// distance, then mean rank distance) with a handoff between them.
// Reset clears the controller and the sample count; stores need no clear.
// The receiver cannot stall; results appear as one-cycle strobes.
module pairwise_distance_midrank_summary (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pdms_pkg::t_in_item  i_in,
    output logic                o_valid,
    output pdms_pkg::t_out_item o_out
);

    pdms_pkg::t_cmd    w_cmd;
    pdms_pkg::t_status w_status;

    pdms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_in(i_in),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(busy)
    );

    pdms_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_cmd(w_cmd),
        .o_status(w_status), .o_valid(o_valid), .o_out(o_out)
    );

endmodule
